@@ hdl/sil_pkg.sv @@
package sil_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 256;
  localparam int unsigned ENTRY_W         = 56;
  localparam logic [7:0]  KEY_START       = 8'hAC;
  localparam logic [7:0]  KEY_STEP        = 8'h67;
  localparam logic [2:0]  LAST_BYTE_POS   = 3'd7;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  index_byte;
    logic [15:0] lookup_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  plain_byte;
    logic [23:0] entry_offset;
    logic [15:0] entry_size;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [7:0] index_byte;
  } ldr_cmd_t;

  typedef struct packed {
    logic               complete;
    logic [7:0]         plain;
    logic [ENTRY_W-1:0] entry;
  } ldr_res_t;

endpackage

@@ hdl/scrambled_index_loader_lookup.sv @@
// Scrambled archive index loader with id lookup. Send action 0 to start a new
// index, action 1 with one scrambled index byte at a time (every eighth byte
// completes an entry and stores it unless the table is full), and action 2 with
// an id to search the stored entries in load order. Every item gives exactly one
// result item. One item is in work at a time. Start, load and the unused action
// place their result in the pending register in the cycle after accept.
// A lookup reads the stored entries up to the first match (all of them when
// none matches); the entry RAM delivers one entry per cycle through its single
// registered read port, and a lookup on an empty table needs no scan. A result
// is parked in a pending register, so the next item is accepted while the
// output register still holds an earlier result. The entry RAM needs no
// clearing pass: only entries below the entry count are ever read.
module scrambled_index_loader_lookup
  import sil_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  fsm_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] req_idx_r, req_idx_nxt;
  logic [15:0]      id_r, id_nxt;
  logic             rsp_vld_r, rsp_last_r;

  out_item_t pend_r, pend_nxt;
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t out_r;
  logic      out_valid_r;
  logic      pend_move;

  logic     in_acc;
  action_t  act;
  ldr_cmd_t ldr_cmd;
  ldr_res_t ldr_res;
  logic     full;
  logic     wr_en;
  logic     rd_en;
  logic     rd_last;
  logic [ENTRY_W-1:0] rd_data;

  assign act    = action_t'(in_data.action);
  assign in_acc = in_valid && !in_stall;
  assign full   = (cnt_r == CNT_MAX);

  // Unscramble and assemble entries
  assign ldr_cmd.clear      = in_acc && (act == ACT_START);
  assign ldr_cmd.load       = in_acc && (act == ACT_LOAD);
  assign ldr_cmd.index_byte = in_data.index_byte;

  sil_loader u_loader (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ldr_cmd),
    .res   (ldr_res)
  );

  // Append a completed entry unless the table is full
  assign wr_en = ldr_res.complete && !full;

  // Issue one read per cycle while the scan still has entries left
  assign rd_en   = (state_r == S_SCAN) && (req_idx_r < cnt_r);
  assign rd_last = (req_idx_r == cnt_r - CNT_W'(1));

  sil_entry_ram #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (ldr_res.entry),
    .rd_en   (rd_en),
    .rd_addr (req_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Move the pending result out when the output register is free or drains
  assign pend_move = pend_valid_r && (!out_valid_r || !out_stall);

  // Hold off new items while scanning or while a result is still pending
  assign in_stall = (state_r != S_IDLE) || pend_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    req_idx_nxt    = req_idx_r;
    id_nxt         = id_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r && !pend_move;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_nxt       = '0;
          pend_nxt.status = ST_OK;
          pend_valid_nxt = 1'b1;
          case (act)
            ACT_START: begin
              cnt_nxt = '0;
            end
            ACT_LOAD: begin
              pend_nxt.plain_byte = ldr_res.plain;
              if (ldr_res.complete) begin
                if (full) begin
                  pend_nxt.status = ST_FULL;
                end else begin
                  cnt_nxt = cnt_r + CNT_W'(1);
                  if (ldr_res.plain != 8'd0) begin
                    pend_nxt.status = ST_RESERVED;
                  end
                end
              end
            end
            ACT_LOOKUP: begin
              if (cnt_r == '0) begin
                pend_nxt.status = ST_NOT_FOUND;
              end else begin
                // defer the result until the scan ends
                pend_valid_nxt = 1'b0;
                id_nxt         = in_data.lookup_id;
                req_idx_nxt    = '0;
                state_nxt      = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          req_idx_nxt = req_idx_r + CNT_W'(1);
        end
        if (rsp_vld_r) begin
          if (rd_data[15:0] == id_r) begin
            pend_nxt.status       = ST_OK;
            pend_nxt.plain_byte   = '0;
            pend_nxt.entry_offset = rd_data[39:16];
            pend_nxt.entry_size   = rd_data[55:40];
            pend_valid_nxt        = 1'b1;
            state_nxt             = S_IDLE;
          end else if (rsp_last_r) begin
            pend_nxt        = '0;
            pend_nxt.status = ST_NOT_FOUND;
            pend_valid_nxt  = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      req_idx_r    <= '0;
      rsp_vld_r    <= 1'b0;
      rsp_last_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      req_idx_r    <= req_idx_nxt;
      rsp_vld_r    <= rd_en;
      rsp_last_r   <= rd_last;
      pend_valid_r <= pend_valid_nxt;
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    pend_r <= pend_nxt;
    if (pend_move) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // No item may enter while a scan is running
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> in_stall)
    else $error("item accepted during scan");

  // The table never grows past its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CNT_MAX))
    else $error("entry written beyond table depth");

  // A pending result stays until it moves to the output register
  a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !pend_move) |=> (pend_valid_r && $stable(pend_r)))
    else $error("pending result lost or changed");

  // A scan read response only arrives while scanning
  a_rsp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r |-> ($past(state_r) == S_SCAN))
    else $error("read response outside a scan");
`endif

endmodule

@@ hdl/sil_entry_ram.sv @@
module sil_entry_ram
  import sil_pkg::*;
#(
  parameter int unsigned DEPTH  = DEF_MAX_ENTRIES,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/sil_loader.sv @@
module sil_loader
  import sil_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ldr_cmd_t cmd,
  output ldr_res_t res
);

  logic [7:0]         key_r, key_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [ENTRY_W-1:0] buf_r, buf_nxt;
  logic [7:0]         rot;
  logic [7:0]         plain;

  // rotate left two, then add the running key
  assign rot   = {cmd.index_byte[5:0], cmd.index_byte[7:6]};
  assign plain = rot + key_r;

  always_comb begin
    key_nxt = key_r;
    pos_nxt = pos_r;
    buf_nxt = buf_r;
    if (cmd.clear) begin
      key_nxt = KEY_START;
      pos_nxt = '0;
      buf_nxt = '0;
    end else if (cmd.load) begin
      key_nxt = key_r + KEY_STEP;
      if (pos_r == LAST_BYTE_POS) begin
        pos_nxt = '0;
        buf_nxt = '0;
      end else begin
        pos_nxt = pos_r + 3'd1;
        buf_nxt[{pos_r, 3'b000} +: 8] = plain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_START;
      pos_r <= '0;
      buf_r <= '0;
    end else begin
      key_r <= key_nxt;
      pos_r <= pos_nxt;
      buf_r <= buf_nxt;
    end
  end

  assign res.complete = cmd.load && (pos_r == LAST_BYTE_POS);
  assign res.plain    = plain;
  assign res.entry    = buf_r;

endmodule
